// File: design/ritoa_pkg.sv
`default_nettype none

package ritoa_pkg;

  // Elaboration defaults and fixed geometry
  localparam int MAX_FIELD_DEF = 128;
  localparam int MAX_BEATS     = 16;
  localparam int BEAT_CHARS    = 8;
  localparam int DIG_SLOTS     = 64;
  localparam int BCD_DIGITS    = 20;

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LOW_A = 8'h61;

  typedef enum logic [1:0] {
    RADIX_BIN,
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  // Register indexes on the config port (byte address / 4)
  typedef enum logic [2:0] {
    REG_RADIX_SEL,
    REG_PRECISION_SET,
    REG_MIN_DIGITS,
    REG_FIELD_WIDTH,
    REG_FILL_CHAR,
    REG_SHOW_PREFIX,
    REG_SHOW_PLUS
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FILL,
    ST_SCAN,
    ST_SIZE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [63:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic        last;
  } out_beat_t;

  // Sequencer commands to the digit unit
  typedef struct packed {
    logic       load;
    logic       dabble;
    logic       fill;
    logic       norm;
    logic       take;
    logic [3:0] take_cnt;
  } dig_ctl_t;

  // Digit unit status: top eight digit slots, [0] the most significant
  typedef struct packed {
    logic [7:0][3:0] top;
    logic            top_zero;
  } dig_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOW_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic logic [7:0] prefix_char(input radix_t r);
    logic [7:0] c;
    unique case (r)
      RADIX_BIN: c = CH_B;
      RADIX_OCT: c = CH_O;
      RADIX_DEC: c = CH_ZERO;
      RADIX_HEX: c = CH_X;
    endcase
    return c;
  endfunction

  // Digit positions a 64-bit magnitude can need in each radix
  function automatic logic [6:0] max_digits(input radix_t r);
    logic [6:0] n;
    unique case (r)
      RADIX_BIN: n = 7'd64;
      RADIX_OCT: n = 7'd22;
      RADIX_DEC: n = 7'd20;
      RADIX_HEX: n = 7'd16;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// File: design/ritoa_digit_unit.sv
`default_nettype none

module ritoa_digit_unit (
  input  wire                  clk,
  input  ritoa_pkg::dig_ctl_t  ctl,
  input  ritoa_pkg::radix_t    radix,
  input  wire  [63:0]          load_mag,
  output ritoa_pkg::dig_stat_t stat
);

  logic [63:0]       mag_r;
  logic [19:0][3:0]  bcd_r;
  logic [63:0][3:0]  dig_r;

  logic [19:0][3:0]  bcd_adj;
  logic [65:0]       mag_ext;
  logic [63:0][3:0]  bin_d;
  logic [21:0][3:0]  oct_d;
  logic [15:0][3:0]  hex_d;
  logic [63:0][3:0]  dig_fill;

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    for (int i = 0; i < ritoa_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  // digit slots per radix, most significant possible digit in slot 63
  always_comb begin
    mag_ext = {2'b00, mag_r};
    for (int i = 0; i < 64; i++) begin
      bin_d[i] = {3'b000, mag_r[i]};
    end
    for (int i = 0; i < 22; i++) begin
      oct_d[i] = {1'b0, mag_ext[3*i +: 3]};
    end
    for (int i = 0; i < 16; i++) begin
      hex_d[i] = mag_r[4*i +: 4];
    end
    unique case (radix)
      ritoa_pkg::RADIX_BIN: dig_fill = bin_d;
      ritoa_pkg::RADIX_OCT: dig_fill = {oct_d, 168'd0};
      ritoa_pkg::RADIX_DEC: dig_fill = {bcd_r, 176'd0};
      ritoa_pkg::RADIX_HEX: dig_fill = {hex_d, 192'd0};
    endcase
  end

  // magnitude and double-dabble registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag_r <= load_mag;
      bcd_r <= '0;
    end else if (ctl.dabble) begin
      bcd_r <= 80'({bcd_adj, mag_r[63]});
      mag_r <= {mag_r[62:0], 1'b0};
    end
  end

  // digit shifter: normalise one digit a step, consume up to eight a beat
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      dig_r <= dig_fill;
    end else if (ctl.norm) begin
      dig_r <= {dig_r[62:0], 4'h0};
    end else if (ctl.take) begin
      dig_r <= dig_r << {ctl.take_cnt, 2'b00};
    end
  end

  always_comb begin
    for (int k = 0; k < ritoa_pkg::BEAT_CHARS; k++) begin
      stat.top[k] = dig_r[63-k];
    end
    stat.top_zero = (dig_r[63] == 4'h0);
  end

endmodule

`default_nettype wire

// File: design/radix_integer_to_ascii.sv
// Integer to ASCII formatter.
// Input channel (in_valid / in_stall / in_payload): one beat carries cmd
// (1 = signed) and a 64-bit value. The block stalls its input while it works.
// Output channel (out_valid / out_stall / out_payload): the text in beats of
// up to eight characters, first character in the low byte, last set on the
// final beat. Empty text gives one beat with char_count 0 and last set.
// Config: APB-style write/read, registers at byte addresses 0,4,..,24; only
// write while the block is idle.
// Per value: for decimal, one double-dabble shift per magnitude bit; then
// the digit slots are filled and the shared digit shifter normalises the
// leading zero slots one slot a cycle (at most 64 binary, 22 octal, 20
// decimal, 16 hex); then the lengths are sized and the output beats (up to
// 16) are emitted, one per cycle while out_stall is low.
// A stalled output beat is held in the output register and emission pauses.
// The next value is accepted once the last beat has been loaded.
// Reset: config registers return to their reset values, block idle, no beat valid.

`default_nettype none

module radix_integer_to_ascii #(
  parameter int MAX_FIELD = ritoa_pkg::MAX_FIELD_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ritoa_pkg::in_beat_t  in_payload,
  output logic                 out_valid,
  input  wire                  out_stall,
  output ritoa_pkg::out_beat_t out_payload,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [4:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int TEXT_CAP_BEATS = ritoa_pkg::MAX_BEATS * ritoa_pkg::BEAT_CHARS;
  localparam int TEXT_CAP = (MAX_FIELD < TEXT_CAP_BEATS) ? MAX_FIELD : TEXT_CAP_BEATS;
  localparam int LEN_W = $clog2(TEXT_CAP + 1);
  localparam logic [8:0] CAP9 = 9'(TEXT_CAP);

  // config registers
  ritoa_pkg::radix_t radix_r;
  logic              prec_set_r;
  logic [7:0]        min_digits_r;
  logic [7:0]        field_width_r;
  logic [7:0]        fill_char_r;
  logic              show_prefix_r;
  logic              show_plus_r;

  // sequencer
  ritoa_pkg::state_t state_r, state_nxt;
  logic [5:0]        conv_cnt_r;
  logic [6:0]        ndig_r;
  logic              neg_r;
  logic [7:0]        nd_r;
  logic [8:0]        pre_end_r;
  logic [LEN_W-1:0]  rem_r;
  logic [6:0]        rd_r;
  logic              out_valid_r;
  ritoa_pkg::out_beat_t out_payload_r;

  ritoa_pkg::dig_ctl_t  dctl;
  ritoa_pkg::dig_stat_t dstat;

  logic        cfg_wr;
  logic        in_acc;
  logic        emit_go;
  logic        scan_done;
  logic [63:0] load_mag;
  logic        load_neg;

  logic [7:0] prec8;
  logic [7:0] nd8;
  logic [8:0] pre_end9;
  logic [8:0] core9;
  logic [8:0] total9;
  logic [8:0] len9;

  logic [7:0]      lane_on;
  logic [7:0]      lane_dig;
  logic [7:0][8:0] lane_p;
  logic [7:0][2:0] lane_off;
  logic [7:0][7:0] lane_ch;
  logic [7:0]      fill_eff;
  logic [7:0]      sign_ch;
  logic            sign_on;
  logic [3:0]      beat_cnt;
  logic            beat_last;
  logic [3:0]      take_cnt;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_stall  = (state_r != ritoa_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_payload = out_payload_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= ritoa_pkg::RADIX_DEC;
      prec_set_r    <= 1'b0;
      min_digits_r  <= 8'd1;
      field_width_r <= 8'd0;
      fill_char_r   <= ritoa_pkg::CH_SPACE;
      show_prefix_r <= 1'b0;
      show_plus_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        ritoa_pkg::REG_RADIX_SEL:     radix_r       <= ritoa_pkg::radix_t'(pwdata[1:0]);
        ritoa_pkg::REG_PRECISION_SET: prec_set_r    <= pwdata[0];
        ritoa_pkg::REG_MIN_DIGITS:    min_digits_r  <= pwdata[7:0];
        ritoa_pkg::REG_FIELD_WIDTH:   field_width_r <= pwdata[7:0];
        ritoa_pkg::REG_FILL_CHAR:     fill_char_r   <= pwdata[7:0];
        ritoa_pkg::REG_SHOW_PREFIX:   show_prefix_r <= pwdata[0];
        ritoa_pkg::REG_SHOW_PLUS:     show_plus_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    case (paddr[4:2])
      ritoa_pkg::REG_RADIX_SEL:     prdata = {30'd0, radix_r};
      ritoa_pkg::REG_PRECISION_SET: prdata = {31'd0, prec_set_r};
      ritoa_pkg::REG_MIN_DIGITS:    prdata = {24'd0, min_digits_r};
      ritoa_pkg::REG_FIELD_WIDTH:   prdata = {24'd0, field_width_r};
      ritoa_pkg::REG_FILL_CHAR:     prdata = {24'd0, fill_char_r};
      ritoa_pkg::REG_SHOW_PREFIX:   prdata = {31'd0, show_prefix_r};
      ritoa_pkg::REG_SHOW_PLUS:     prdata = {31'd0, show_plus_r};
      default:                      prdata = 32'd0;
    endcase
  end

  // sign and magnitude of the incoming value
  assign load_neg = in_payload.cmd && in_payload.value[63];
  assign load_mag = load_neg ? (64'd0 - in_payload.value) : in_payload.value;

  assign scan_done = (ndig_r == 7'd0) || !dstat.top_zero;
  assign emit_go   = (state_r == ritoa_pkg::ST_EMIT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (radix_r == ritoa_pkg::RADIX_DEC) ? ritoa_pkg::ST_CONV
                                                        : ritoa_pkg::ST_FILL;
        end
      end
      ritoa_pkg::ST_CONV: begin
        if (conv_cnt_r == 6'd63) state_nxt = ritoa_pkg::ST_FILL;
      end
      ritoa_pkg::ST_FILL: state_nxt = ritoa_pkg::ST_SCAN;
      ritoa_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = ritoa_pkg::ST_SIZE;
      end
      ritoa_pkg::ST_SIZE: state_nxt = ritoa_pkg::ST_EMIT;
      ritoa_pkg::ST_EMIT: begin
        if (emit_go && beat_last) state_nxt = ritoa_pkg::ST_IDLE;
      end
      default: state_nxt = ritoa_pkg::ST_IDLE;
    endcase
  end

  // digit unit commands
  always_comb begin
    dctl          = '0;
    dctl.take_cnt = take_cnt;
    unique case (state_r)
      ritoa_pkg::ST_IDLE: dctl.load   = in_acc;
      ritoa_pkg::ST_CONV: dctl.dabble = 1'b1;
      ritoa_pkg::ST_FILL: dctl.fill   = 1'b1;
      ritoa_pkg::ST_SCAN: dctl.norm   = !scan_done;
      ritoa_pkg::ST_SIZE: ;
      ritoa_pkg::ST_EMIT: dctl.take   = emit_go;
      default: ;
    endcase
  end

  ritoa_digit_unit u_digits (
    .clk      (clk),
    .ctl      (dctl),
    .radix    (radix_r),
    .load_mag (load_mag),
    .stat     (dstat)
  );

  // text length: digits, zero pad, prefix, sign, then fill
  always_comb begin
    prec8    = prec_set_r ? min_digits_r : 8'd1;
    nd8      = (8'(ndig_r) > prec8) ? 8'(ndig_r) : prec8;
    pre_end9 = 9'(nd8) + (show_prefix_r ? 9'd2 : 9'd0);
    core9    = pre_end9 + 9'(neg_r || show_plus_r);
    total9   = (core9 > 9'(field_width_r)) ? core9 : 9'(field_width_r);
    len9     = (total9 > CAP9) ? CAP9 : total9;
  end

  // lane characters of the current beat; lane_p counts from the right end
  always_comb begin
    fill_eff = prec_set_r ? ritoa_pkg::CH_SPACE : fill_char_r;
    sign_ch  = neg_r ? ritoa_pkg::CH_MINUS : ritoa_pkg::CH_PLUS;
    sign_on  = neg_r || show_plus_r;
    for (int j = 0; j < ritoa_pkg::BEAT_CHARS; j++) begin
      lane_on[j]  = rem_r > LEN_W'(j);
      lane_p[j]   = 9'(rem_r) - 9'(j + 1);
      lane_dig[j] = lane_on[j] && (lane_p[j] < 9'(rd_r));
      lane_off[j] = 3'(9'(rd_r) - 9'd1 - lane_p[j]);
      priority if (!lane_on[j]) begin
        lane_ch[j] = 8'h00;
      end else if (lane_dig[j]) begin
        lane_ch[j] = ritoa_pkg::digit_char(dstat.top[lane_off[j]]);
      end else if (lane_p[j] < 9'(nd_r)) begin
        lane_ch[j] = ritoa_pkg::CH_ZERO;
      end else if (lane_p[j] < pre_end_r) begin
        lane_ch[j] = (lane_p[j] == 9'(nd_r)) ? ritoa_pkg::prefix_char(radix_r)
                                             : ritoa_pkg::CH_ZERO;
      end else if (sign_on && (lane_p[j] == pre_end_r)) begin
        lane_ch[j] = sign_ch;
      end else begin
        lane_ch[j] = fill_eff;
      end
    end
    beat_last = rem_r <= LEN_W'(ritoa_pkg::BEAT_CHARS);
    beat_cnt  = beat_last ? 4'(rem_r) : 4'(ritoa_pkg::BEAT_CHARS);
    take_cnt  = 4'($countones(lane_dig));
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ritoa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // counters and per-value lengths
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r      <= load_neg;
      conv_cnt_r <= 6'd0;
    end else if (state_r == ritoa_pkg::ST_CONV) begin
      conv_cnt_r <= conv_cnt_r + 6'd1;
    end
    if (state_r == ritoa_pkg::ST_FILL) begin
      ndig_r <= ritoa_pkg::max_digits(radix_r);
    end else if (dctl.norm) begin
      ndig_r <= ndig_r - 7'd1;
    end
    if (state_r == ritoa_pkg::ST_SIZE) begin
      nd_r      <= nd8;
      pre_end_r <= pre_end9;
      rem_r     <= LEN_W'(len9);
      rd_r      <= ndig_r;
    end else if (emit_go) begin
      rem_r <= rem_r - LEN_W'(beat_cnt);
      rd_r  <= rd_r - 7'(take_cnt);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_payload_r.chars      <= lane_ch;
      out_payload_r.char_count <= beat_cnt;
      out_payload_r.last       <= beat_last;
    end
  end

`ifndef SYNTH
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_payload.char_count == 4'd0) |-> out_payload.last)
    else $error("empty beat without last");

  a_full_unless_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.last |-> out_payload.char_count == 4'd8)
    else $error("short beat before the last one");

  a_digits_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ritoa_pkg::ST_EMIT) |-> (9'(rd_r) <= 9'(rem_r)))
    else $error("more digits left than characters");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != ritoa_pkg::ST_IDLE)
    else $error("accepted value did not start work");
`endif

endmodule

`default_nettype wire
